/* sv/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

   // Result list: one input byte yields at most six results
   localparam int ListDepth = 6;
   localparam int CntWidth  = 3;

   // Status codes
   localparam logic [2:0] StOk      = 3'd0;
   localparam logic [2:0] StClosed  = 3'd1;
   localparam logic [2:0] StNoQuote = 3'd2;
   localparam logic [2:0] StBadEsc  = 3'd3;
   localparam logic [2:0] StBadHex  = 3'd4;
   localparam logic [2:0] StEndStr  = 3'd5;
   localparam logic [2:0] StEndEsc  = 3'd6;
   localparam logic [2:0] StEndHex  = 3'd7;

   // Input kind carried in tuser
   localparam logic CmdByte = 1'b0;
   localparam logic CmdEnd  = 1'b1;

   // Characters of interest
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChSlash  = 8'h2F;
   localparam logic [7:0] ChLowB   = 8'h62;
   localparam logic [7:0] ChLowF   = 8'h66;
   localparam logic [7:0] ChLowN   = 8'h6E;
   localparam logic [7:0] ChLowR   = 8'h72;
   localparam logic [7:0] ChLowT   = 8'h74;
   localparam logic [7:0] ChLowU   = 8'h75;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChLowA   = 8'h61;
   localparam logic [7:0] ChUpA    = 8'h41;
   localparam logic [7:0] ChUpF    = 8'h46;
   localparam logic [7:0] ChBs     = 8'h08;
   localparam logic [7:0] ChFf     = 8'h0C;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChTab    = 8'h09;

   // Top six bits of a surrogate (D800..DBFF high, DC00..DFFF low)
   localparam logic [5:0] SurHighTag = 6'h36;
   localparam logic [5:0] SurLowTag  = 6'h37;
   localparam logic [20:0] SupplBase = 21'h10000;

   typedef enum logic [2:0] {
      PhIdle   = 3'd0,
      PhStr    = 3'd1,
      PhEsc    = 3'd2,
      PhHex1   = 3'd3,
      PhHeld   = 3'd4,
      PhHeldBs = 3'd5,
      PhHex2   = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  hex_cnt;
      logic [15:0] code_acc;
      logic [15:0] held_high;
   } state_type;

   localparam state_type StateReset = '{phase: PhIdle, hex_cnt: 2'd0,
                                        code_acc: 16'd0, held_high: 16'd0};

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic [2:0] status;
   } rsp_ent_type;

   typedef struct packed {
      rsp_ent_type [ListDepth-1:0] ent;
      logic [CntWidth-1:0]         cnt;
   } rsp_list_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] b;
   } esc_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   // Append one result entry
   function automatic rsp_list_type list_push(rsp_list_type l, logic [7:0] b,
                                              logic v, logic [2:0] st);
      rsp_list_type r;
      r = l;
      r.ent[l.cnt] = '{data: b, valid: v, status: st};
      r.cnt = l.cnt + CntWidth'(1);
      return r;
   endfunction

   function automatic rsp_list_type list_byte(rsp_list_type l, logic [7:0] b);
      return list_push(l, b, 1'b1, StOk);
   endfunction

   function automatic rsp_list_type list_status(rsp_list_type l, logic [2:0] st);
      return list_push(l, 8'h00, 1'b0, st);
   endfunction

   // Append the UTF-8 encoding of a code point
   function automatic rsp_list_type list_utf8(rsp_list_type l, logic [20:0] cp);
      rsp_list_type r;
      r = l;
      if (cp < 21'h80) begin
         r = list_byte(r, cp[7:0]);
      end else if (cp < 21'h800) begin
         r = list_byte(r, {3'b110, cp[10:6]});
         r = list_byte(r, {2'b10, cp[5:0]});
      end else if (cp < SupplBase) begin
         r = list_byte(r, {4'b1110, cp[15:12]});
         r = list_byte(r, {2'b10, cp[11:6]});
         r = list_byte(r, {2'b10, cp[5:0]});
      end else begin
         r = list_byte(r, {5'b11110, cp[20:18]});
         r = list_byte(r, {2'b10, cp[17:12]});
         r = list_byte(r, {2'b10, cp[11:6]});
         r = list_byte(r, {2'b10, cp[5:0]});
      end
      return r;
   endfunction

   // Simple escapes (not u)
   function automatic esc_type esc_map(logic [7:0] c);
      esc_type r;
      r.ok = 1'b1;
      case (c)
         ChQuote:  r.b = ChQuote;
         ChBslash: r.b = ChBslash;
         ChSlash:  r.b = ChSlash;
         ChLowB:   r.b = ChBs;
         ChLowF:   r.b = ChFf;
         ChLowN:   r.b = ChLf;
         ChLowR:   r.b = ChCr;
         ChLowT:   r.b = ChTab;
         default: begin
            r.ok = 1'b0;
            r.b  = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic hex_type hex_val(logic [7:0] c);
      hex_type    r;
      logic [7:0] d;
      r.ok = 1'b1;
      d    = 8'h00;
      if (c >= ChZero && c <= ChNine) begin
         d = c - ChZero;
      end else if (c >= ChLowA && c <= ChLowF) begin
         d = c - ChLowA + 8'd10;
      end else if (c >= ChUpA && c <= ChUpF) begin
         d = c - ChUpA + 8'd10;
      end else begin
         r.ok = 1'b0;
      end
      r.val = d[3:0];
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/jsu_decode.sv */
`default_nettype none

// Per-byte decode: current state and one input item give the next state
// and the full list of results for that item.
module jsu_decode
   import jsu_pkg::*;
(
   input  var state_type    cur,
   input  var logic         cmd,
   input  var logic [7:0]   in_byte,
   output state_type        nxt,
   output rsp_list_type     list
);

   logic         do_str;
   logic         do_esc;
   esc_type      esc;
   hex_type      hx;
   logic [15:0]  acc_new;
   logic [20:0]  held_cp;
   logic [20:0]  pair_cp;
   rsp_list_type l;

   always_comb begin
      nxt     = cur;
      l       = '0;
      do_str  = 1'b0;
      do_esc  = 1'b0;
      esc     = esc_map(in_byte);
      hx      = hex_val(in_byte);
      acc_new = {cur.code_acc[11:0], hx.val};
      held_cp = {5'd0, cur.held_high};
      pair_cp = SupplBase + 21'({cur.held_high[9:0], acc_new[9:0]});

      if (cmd == CmdEnd) begin
         // end of input: flush a held surrogate, then report
         case (cur.phase)
            PhStr:  l = list_status(l, StEndStr);
            PhEsc:  l = list_status(l, StEndEsc);
            PhHex1, PhHex2: l = list_status(l, StEndHex);
            PhHeld: begin
               l = list_utf8(l, held_cp);
               l = list_status(l, StEndStr);
            end
            PhHeldBs: begin
               l = list_utf8(l, held_cp);
               l = list_status(l, StEndEsc);
            end
            default: l = list_status(l, StNoQuote);
         endcase
         nxt = StateReset;
      end else begin
         case (cur.phase)
            PhStr: do_str = 1'b1;
            PhEsc: begin
               if (in_byte == ChLowU) begin
                  nxt.phase    = PhHex1;
                  nxt.hex_cnt  = 2'd0;
                  nxt.code_acc = 16'd0;
               end else begin
                  do_esc = 1'b1;
               end
            end
            PhHex1, PhHex2: begin
               if (!hx.ok) begin
                  l   = list_status(l, StBadHex);
                  nxt = StateReset;
               end else if (cur.hex_cnt != 2'd3) begin
                  nxt.hex_cnt  = cur.hex_cnt + 2'd1;
                  nxt.code_acc = acc_new;
               end else begin
                  nxt.hex_cnt  = 2'd0;
                  nxt.code_acc = 16'd0;
                  if (cur.phase == PhHex1) begin
                     if (acc_new[15:10] == SurHighTag) begin
                        nxt.held_high = acc_new;
                        nxt.phase     = PhHeld;
                     end else begin
                        l         = list_utf8(l, {5'd0, acc_new});
                        nxt.phase = PhStr;
                     end
                  end else begin
                     // second escape: join a low surrogate, else both alone
                     if (acc_new[15:10] == SurLowTag) begin
                        l = list_utf8(l, pair_cp);
                     end else begin
                        l = list_utf8(l, held_cp);
                        l = list_utf8(l, {5'd0, acc_new});
                     end
                     nxt.held_high = 16'd0;
                     nxt.phase     = PhStr;
                  end
               end
            end
            PhHeld: begin
               if (in_byte == ChBslash) begin
                  nxt.phase = PhHeldBs;
               end else begin
                  l             = list_utf8(l, held_cp);
                  nxt.held_high = 16'd0;
                  nxt.phase     = PhStr;
                  do_str        = 1'b1;
               end
            end
            PhHeldBs: begin
               if (in_byte == ChLowU) begin
                  nxt.phase    = PhHex2;
                  nxt.hex_cnt  = 2'd0;
                  nxt.code_acc = 16'd0;
               end else begin
                  l             = list_utf8(l, held_cp);
                  nxt.held_high = 16'd0;
                  do_esc        = 1'b1;
               end
            end
            default: begin
               if (in_byte == ChQuote) begin
                  nxt       = StateReset;
                  nxt.phase = PhStr;
               end else begin
                  l   = list_status(l, StNoQuote);
                  nxt = StateReset;
               end
            end
         endcase

         // plain string byte
         if (do_str) begin
            if (in_byte == ChQuote) begin
               l   = list_status(l, StClosed);
               nxt = StateReset;
            end else if (in_byte == ChBslash) begin
               nxt.phase = PhEsc;
            end else begin
               l = list_byte(l, in_byte);
            end
         end

         // character after a backslash
         if (do_esc) begin
            if (esc.ok) begin
               l         = list_byte(l, esc.b);
               nxt.phase = PhStr;
            end else begin
               l   = list_status(l, StBadEsc);
               nxt = StateReset;
            end
         end
      end
   end

   assign list = l;

endmodule

`default_nettype wire

/* sv/jsu_out_queue.sv */
`default_nettype none

// Result register: holds one item's result list and sends it out one
// entry per transfer.
module jsu_out_queue
   import jsu_pkg::*;
(
   input  var logic         clock,
   input  var logic         reset,
   input  var logic         load,
   input  var rsp_list_type list,
   output logic             can_load,
   output logic             rsp_tvalid,
   input  var logic         rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte
   output logic [3:0]       rsp_tuser,  // byte_valid, status[2:0]
   output logic             rsp_tlast   // last
);

   rsp_ent_type [ListDepth-1:0] ent_ff;
   logic [CntWidth-1:0]         cnt_ff, cnt_in;
   logic [CntWidth-1:0]         idx_ff, idx_in;
   rsp_ent_type                 cur;
   logic                        is_last;
   logic                        fire;

   assign cur        = ent_ff[idx_ff];
   assign rsp_tvalid = (cnt_ff != '0);
   assign is_last    = (idx_ff == cnt_ff - CntWidth'(1));
   assign fire       = rsp_tvalid && rsp_tready;
   assign can_load   = !rsp_tvalid || (fire && is_last);

   assign rsp_tdata = cur.data;
   assign rsp_tuser = {cur.status, cur.valid};
   assign rsp_tlast = is_last;

   // index and fill count
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = list.cnt;
         idx_in = '0;
      end else if (fire) begin
         if (is_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + CntWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // list payload
   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= list.ent;
      end
   end

endmodule

`default_nettype wire

/* sv/json_string_unescape_utf8_unit.sv */
// JSON string unescaper with UTF-8 output.
// req channel: one transfer per input byte of a quoted string literal,
// starting with the opening quote; req_tuser = 1 marks end of input and
// req_tdata is then ignored. rsp channel: one transfer per result, with
// the decoded byte in rsp_tdata, byte_valid in rsp_tuser[0], status in
// rsp_tuser[3:1] and rsp_tlast on the final result of an input byte.
// An input byte yields zero to six results; a status result (closed
// string or an error) always comes last and returns the block to idle.
// A byte's req transfer goes to the input register, then through decode
// into the result register, where its first result appears.
// Throughput: one input byte per cycle while each byte gives at most one
// result and rsp_tready stays high; a byte with more results holds the
// input while the single result register drains one entry per transfer.
// Reset (synchronous, active high) returns the decoder to idle, awaiting
// an opening quote, and drops any pending results.
// When rsp_tready is low, the result register holds and the input
// register takes one more byte before req_tready falls.
`default_nettype none

module json_string_unescape_utf8_unit
   import jsu_pkg::*;
(
   input  var logic       clock,
   input  var logic       reset,
   input  var logic       req_tvalid,
   output logic           req_tready,
   input  var logic [7:0] req_tdata,  // in_byte
   input  var logic       req_tuser,  // cmd
   output logic           rsp_tvalid,
   input  var logic       rsp_tready,
   output logic [7:0]     rsp_tdata,  // out_byte
   output logic [3:0]     rsp_tuser,  // byte_valid, status[2:0]
   output logic           rsp_tlast   // last
);

   logic         in_valid_ff, in_valid_in;
   logic         in_cmd_ff;
   logic [7:0]   in_byte_ff;
   state_type    state_ff, state_in;
   state_type    state_in_dec;
   rsp_list_type list;
   logic         can_load;
   logic         move;
   logic         req_fire;

   assign move       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || move;
   assign req_fire   = req_tvalid && req_tready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= StateReset;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // decode
   jsu_decode u_decode (
      .cur     (state_ff),
      .cmd     (in_cmd_ff),
      .in_byte (in_byte_ff),
      .nxt     (state_in_dec),
      .list    (list)
   );

   assign state_in = move ? state_in_dec : state_ff;

   // result register
   jsu_out_queue u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (move),
      .list       (list),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("results present right after reset");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      move |=> (rsp_tvalid == ($past(list.cnt) != '0)))
      else $error("loaded result list not presented");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3:1] != StOk) |->
         (rsp_tlast && !rsp_tuser[0] && rsp_tdata == 8'h00))
      else $error("status result not final or carries data");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import jsu_pkg::*;

   // One input transfer: cmd travels in tuser, the string byte in tdata
   typedef struct {
      logic       cmd;
      logic [7:0] data;
   } char_item_type;

   // One decoded result as it should appear on the rsp channel
   typedef struct {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] status;
      logic       last;
   } dec_result_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // in_byte
   logic       req_tuser  = 1'b0;   // cmd
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_byte
   logic [3:0] rsp_tuser;           // byte_valid, status[2:0]
   logic       rsp_tlast;           // last

   char_item_type  char_q[$];       // bytes waiting to be offered
   dec_result_type decoded_q[$];    // decoded results not yet seen
   dec_result_type step_res[$];     // scratch list for one input byte

   int   accepted_cnt = 0;
   int   total_items  = 0;
   int   fail_cnt     = 0;
   logic hold_active  = 1'b0;

   // Decoder state kept by the checker
   phase_type   dec_phase   = PhIdle;
   logic [1:0]  dec_hex_cnt = 2'd0;
   logic [15:0] dec_code    = 16'd0;
   logic [15:0] dec_held    = 16'd0;

   json_string_unescape_utf8_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Decoder prediction
   // ---------------------------------------------------------------
   function automatic void put_res(logic [7:0] b, logic v, logic [2:0] st);
      dec_result_type r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.status     = st;
      r.last       = 1'b0;
      step_res.insert(step_res.size(), r);
   endfunction

   function automatic void put_byte(logic [7:0] b);
      put_res(b, 1'b1, StOk);
   endfunction

   // status result, then back to idle
   function automatic void close_with(logic [2:0] st);
      put_res(8'h00, 1'b0, st);
      dec_phase   = PhIdle;
      dec_hex_cnt = 2'd0;
      dec_code    = 16'd0;
      dec_held    = 16'd0;
   endfunction

   function automatic void put_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
         put_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         put_byte(8'hC0 | 8'(cp >> 6));
         put_byte(8'h80 | 8'(cp & 21'h3F));
      end else if (cp < 21'h10000) begin
         put_byte(8'hE0 | 8'(cp >> 12));
         put_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         put_byte(8'h80 | 8'(cp & 21'h3F));
      end else begin
         put_byte(8'hF0 | 8'(cp >> 18));
         put_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
         put_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         put_byte(8'h80 | 8'(cp & 21'h3F));
      end
   endfunction

   function automatic int nibble_of(logic [7:0] c);
      if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
      if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
      if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
      return -1;
   endfunction

   function automatic void str_char(logic [7:0] c);
      if (c == ChQuote) close_with(StClosed);
      else if (c == ChBslash) dec_phase = PhEsc;
      else put_byte(c);
   endfunction

   // character after a backslash, 'u' excluded
   function automatic void esc_char(logic [7:0] e);
      logic [7:0] b;
      case (e)
         ChQuote:  b = ChQuote;
         ChBslash: b = ChBslash;
         ChSlash:  b = ChSlash;
         ChLowB:   b = ChBs;
         ChLowF:   b = ChFf;
         ChLowN:   b = ChLf;
         ChLowR:   b = ChCr;
         ChLowT:   b = ChTab;
         default: begin
            close_with(StBadEsc);
            return;
         end
      endcase
      put_byte(b);
      dec_phase = PhStr;
   endfunction

   function automatic void take_hex_digit(logic [7:0] c);
      int          v;
      logic [15:0] cp;
      v = nibble_of(c);
      if (v < 0) begin
         close_with(StBadHex);
         return;
      end
      dec_code = {dec_code[11:0], 4'(v)};
      if (dec_hex_cnt < 2'd3) begin
         dec_hex_cnt = dec_hex_cnt + 2'd1;
         return;
      end
      dec_hex_cnt = 2'd0;
      cp          = dec_code;
      dec_code    = 16'd0;
      if (dec_phase == PhHex1) begin
         if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            dec_held  = cp;
            dec_phase = PhHeld;
         end else begin
            put_utf8({5'd0, cp});
            dec_phase = PhStr;
         end
      end else begin
         // second escape: join with the held high surrogate if it is a low one
         if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
            put_utf8(21'h10000 + {1'b0, dec_held[9:0], cp[9:0]});
         end else begin
            put_utf8({5'd0, dec_held});
            put_utf8({5'd0, cp});
         end
         dec_held  = 16'd0;
         dec_phase = PhStr;
      end
   endfunction

   function automatic void decode_step(logic cmd, logic [7:0] c);
      step_res.delete();
      if (cmd == CmdEnd) begin
         case (dec_phase)
            PhStr:        close_with(StEndStr);
            PhEsc:        close_with(StEndEsc);
            PhHex1, PhHex2: close_with(StEndHex);
            PhHeld: begin
               put_utf8({5'd0, dec_held});
               close_with(StEndStr);
            end
            PhHeldBs: begin
               put_utf8({5'd0, dec_held});
               close_with(StEndEsc);
            end
            default:      close_with(StNoQuote);
         endcase
      end else begin
         case (dec_phase)
            PhStr: str_char(c);
            PhEsc: begin
               if (c == ChLowU) begin
                  dec_phase   = PhHex1;
                  dec_hex_cnt = 2'd0;
                  dec_code    = 16'd0;
               end else begin
                  esc_char(c);
               end
            end
            PhHex1, PhHex2: take_hex_digit(c);
            PhHeld: begin
               if (c == ChBslash) begin
                  dec_phase = PhHeldBs;
               end else begin
                  put_utf8({5'd0, dec_held});
                  dec_held  = 16'd0;
                  dec_phase = PhStr;
                  str_char(c);
               end
            end
            PhHeldBs: begin
               if (c == ChLowU) begin
                  dec_phase   = PhHex2;
                  dec_hex_cnt = 2'd0;
                  dec_code    = 16'd0;
               end else begin
                  put_utf8({5'd0, dec_held});
                  dec_held = 16'd0;
                  esc_char(c);
               end
            end
            default: begin
               if (c == ChQuote) begin
                  dec_phase   = PhStr;
                  dec_hex_cnt = 2'd0;
                  dec_code    = 16'd0;
                  dec_held    = 16'd0;
               end else begin
                  close_with(StNoQuote);
               end
            end
         endcase
      end
      if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
      foreach (step_res[i]) decoded_q.insert(decoded_q.size(), step_res[i]);
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void add_item(logic cmd, logic [7:0] b);
      char_item_type it;
      it.cmd  = cmd;
      it.data = b;
      char_q.insert(char_q.size(), it);
   endfunction

   function automatic void add_end();
      add_item(CmdEnd, 8'($urandom_range(255, 0)));
   endfunction

   function automatic logic [7:0] hex_ascii(logic [3:0] v);
      if (v < 4'd10) return ChZero + 8'(v);
      return ($urandom_range(1, 0) ? ChUpA : ChLowA) + 8'(v) - 8'd10;
   endfunction

   function automatic void add_hex(logic [15:0] cp);
      add_item(CmdByte, ChBslash);
      add_item(CmdByte, ChLowU);
      for (int i = 3; i >= 0; i--) add_item(CmdByte, hex_ascii(cp[i*4 +: 4]));
   endfunction

   // backslash, u and fewer than four digits
   function automatic void add_hex_partial(int k);
      add_item(CmdByte, ChBslash);
      add_item(CmdByte, ChLowU);
      repeat (k) add_item(CmdByte, hex_ascii(4'($urandom_range(15, 0))));
   endfunction

   function automatic logic [7:0] esc_pick(int i);
      case (i)
         0:       return ChQuote;
         1:       return ChBslash;
         2:       return ChSlash;
         3:       return ChLowB;
         4:       return ChLowF;
         5:       return ChLowN;
         6:       return ChLowR;
         default: return ChLowT;
      endcase
   endfunction

   function automatic bit is_simple_esc(logic [7:0] c);
      for (int i = 0; i < 8; i++) if (esc_pick(i) == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(255, 0)); while (c == ChQuote || c == ChBslash);
      return c;
   endfunction

   function automatic logic [7:0] rand_bad_esc();
      logic [7:0] c;
      do c = 8'($urandom_range(255, 0)); while (is_simple_esc(c) || c == ChLowU);
      return c;
   endfunction

   function automatic logic [7:0] rand_bad_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(255, 0)); while (nibble_of(c) >= 0);
      return c;
   endfunction

   function automatic logic [15:0] rand_high();
      return 16'hD800 + 16'($urandom_range(16'h3FF, 0));
   endfunction

   function automatic logic [15:0] rand_low();
      return 16'hDC00 + 16'($urandom_range(16'h3FF, 0));
   endfunction

   // code point for a \u escape, spread over the UTF-8 length classes
   function automatic logic [15:0] rand_code(bit allow_low);
      case ($urandom_range(5, 0))
         0: return 16'($urandom_range(16'h7F, 0));
         1: return 16'($urandom_range(16'h7FF, 16'h80));
         2: begin
            if ($urandom_range(1, 0)) return 16'($urandom_range(16'hD7FF, 16'h800));
            return 16'($urandom_range(16'hFFFF, 16'hE000));
         end
         3: return rand_high();
         4: return allow_low ? rand_low() : 16'hFFFF;
         default: begin
            case ($urandom_range(5, 0))
               0:       return 16'h0000;
               1:       return 16'h007F;
               2:       return 16'h0080;
               3:       return 16'h07FF;
               4:       return 16'h0800;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   // one well-formed piece of string body
   function automatic void add_segment();
      case ($urandom_range(7, 0))
         0, 1: add_item(CmdByte, rand_plain());
         2: begin
            add_item(CmdByte, ChBslash);
            add_item(CmdByte, esc_pick($urandom_range(7, 0)));
         end
         3: add_hex(rand_code(1'b1));
         4: begin
            add_hex(rand_high());
            add_hex(rand_low());
         end
         5: begin
            add_hex(rand_high());
            add_item(CmdByte, rand_plain());
         end
         6: begin
            add_hex(rand_high());
            add_item(CmdByte, ChBslash);
            add_item(CmdByte, esc_pick($urandom_range(7, 0)));
         end
         default: begin
            // second escape that is not a low surrogate
            add_hex(rand_high());
            add_hex(rand_code(1'b0));
         end
      endcase
   endfunction

   // how a string ends: closed, cut short, or broken
   function automatic void add_ending(int kind);
      case (kind)
         0: add_item(CmdByte, ChQuote);
         1: add_end();
         2: begin
            add_item(CmdByte, ChBslash);
            add_end();
         end
         3: begin
            if ($urandom_range(1, 0)) add_hex(rand_high());
            add_hex_partial($urandom_range(3, 0));
            add_end();
         end
         4: begin
            add_item(CmdByte, ChBslash);
            add_item(CmdByte, rand_bad_esc());
         end
         5: begin
            if ($urandom_range(1, 0)) add_hex(rand_high());
            add_hex_partial($urandom_range(3, 0));
            add_item(CmdByte, rand_bad_hex());
         end
         6: begin
            add_hex(rand_high());
            add_end();
         end
         7: begin
            add_hex(rand_high());
            add_item(CmdByte, ChBslash);
            add_end();
         end
         8: begin
            add_hex(rand_high());
            add_item(CmdByte, ChBslash);
            add_item(CmdByte, rand_bad_esc());
         end
         default: begin
            // closed, then stray bytes while idle
            add_item(CmdByte, ChQuote);
            repeat ($urandom_range(3, 1)) begin
               logic [7:0] c;
               do c = 8'($urandom_range(255, 0)); while (c == ChQuote);
               add_item(CmdByte, c);
            end
            if ($urandom_range(1, 0)) add_end();
         end
      endcase
   endfunction

   // stall mix: sender 14/receiver 87, then swapped, then no idling
   function automatic int stall_stage();
      if (total_items == 0) return 0;
      return (accepted_cnt * 3) / total_items;
   endfunction

   function automatic int send_idle_pct();
      case (stall_stage())
         0:       return 14;
         1:       return 87;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct();
      case (stall_stage())
         0:       return 87;
         1:       return 14;
         default: return 0;
      endcase
   endfunction

   function automatic void check_field(string fname, int want_v, int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want_v, got_v);
         fail_cnt++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers queued bytes, predicts on each accepted transfer
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_p
      char_item_type nxt;
      logic          busy;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            decode_step(req_tuser, req_tdata);
            accepted_cnt <= accepted_cnt + 1;
            busy = 1'b0;
         end
         if (!busy) begin
            if (char_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
               nxt = char_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compares each result transfer with the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_p
      dec_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected result, expected none actual data=%0h user=%0h last=%0b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               fail_cnt++;
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", int'(want.out_byte), int'(rsp_tdata));
               check_field("byte_valid", int'(want.byte_valid), int'(rsp_tuser[0]));
               check_field("status", int'(want.status), int'(rsp_tuser[3:1]));
               check_field("last", int'(want.last), int'(rsp_tlast));
            end
         end
         rsp_tready <= !hold_active && ($urandom_range(99, 0) >= recv_idle_pct());
      end
   end

   // Long receiver hold-off while the sender keeps offering
   initial begin : hold_p
      while (total_items == 0 || accepted_cnt < (total_items * 3) / 4) @(posedge clock);
      hold_active <= 1'b1;
      repeat (300) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Stimulus, reset and end of run
   initial begin : stim_p
      int n_str;
      // extremes: idle errors, min/max bytes, max code points, largest pair
      add_item(CmdByte, 8'h78);
      add_end();
      add_item(CmdByte, ChQuote);
      add_item(CmdByte, 8'h00);
      add_item(CmdByte, 8'hFF);
      add_hex(16'hFFFF);
      add_hex(16'hDBFF);
      add_hex(16'hDFFF);
      add_item(CmdByte, ChQuote);

      // random strings with every ending kind in turn
      n_str = 0;
      while (char_q.size() < 240) begin
         add_item(CmdByte, ChQuote);
         repeat ($urandom_range(6, 1)) add_segment();
         add_ending(n_str % 10);
         n_str++;
      end
      total_items = char_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || req_tvalid) @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Run time limit
   initial begin : limit_p
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* json_string_unescape_utf8_unit.f */
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_out_queue.sv
sv/json_string_unescape_utf8_unit.sv
tb/sv/tb_top.sv
